@@ src/sss_pkg.sv @@
`timescale 1ns / 1ps

package sss_pkg;

   // One script byte and its end-of-script flag
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_script;
   } req_type;

   // One output byte with statement boundary information
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       statement_end;
      logic       statement_kept;
   } rsp_type;

   typedef enum logic [3:0] {
      LX_NORMAL   = 4'd0,
      LX_SQUOTE   = 4'd1,
      LX_DQUOTE   = 4'd2,
      LX_BTICK    = 4'd3,
      LX_BRACKET  = 4'd4,
      LX_LINECMT  = 4'd5,
      LX_BLOCKCMT = 4'd6,
      LX_DASH     = 4'd7,
      LX_SLASH    = 4'd8,
      LX_STAR     = 4'd9,
      LX_SESC     = 4'd10,
      LX_DESC     = 4'd11
   } lex_state_type;

   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BTICK     = 8'h60;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

endpackage

@@ src/sss_lexer.sv @@
`timescale 1ns / 1ps

module sss_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  sss_pkg::req_type item,
   output sss_pkg::rsp_type result
);
   import sss_pkg::*;

   lex_state_type state_ff, state_in;
   logic          seen_ff, seen_in;

   lex_state_type cur;
   lex_state_type nxt;
   logic          resolved;
   logic          sep;
   logic          blank;
   logic          seen_next;
   logic          stmt_end;
   logic [7:0]    c;

   assign c = item.in_byte;

   always_comb begin
      cur      = state_ff;
      nxt      = LX_NORMAL;
      resolved = 1'b0;
      sep      = 1'b0;

      // Complete a pending two-byte token first
      case (state_ff)
         LX_DASH: begin
            if (c == CH_DASH) begin
               nxt      = LX_LINECMT;
               resolved = 1'b1;
            end else begin
               cur = LX_NORMAL;
            end
         end
         LX_SLASH: begin
            if (c == CH_STAR) begin
               nxt      = LX_STAR;
               resolved = 1'b1;
            end else begin
               cur = LX_NORMAL;
            end
         end
         LX_STAR: begin
            if (c == CH_SLASH) begin
               nxt      = LX_NORMAL;
               resolved = 1'b1;
            end else begin
               cur = LX_BLOCKCMT;
            end
         end
         LX_SESC: begin
            nxt      = LX_SQUOTE;
            resolved = 1'b1;
         end
         LX_DESC: begin
            nxt      = LX_DQUOTE;
            resolved = 1'b1;
         end
         default: begin
         end
      endcase

      if (!resolved) begin
         case (cur)
            LX_SQUOTE: begin
               if (c == CH_BACKSLASH)   nxt = LX_SESC;
               else if (c == CH_SQUOTE) nxt = LX_NORMAL;
               else                     nxt = LX_SQUOTE;
            end
            LX_DQUOTE: begin
               if (c == CH_BACKSLASH)   nxt = LX_DESC;
               else if (c == CH_DQUOTE) nxt = LX_NORMAL;
               else                     nxt = LX_DQUOTE;
            end
            LX_BTICK:    nxt = (c == CH_BTICK) ? LX_NORMAL : LX_BTICK;
            LX_BRACKET:  nxt = (c == CH_RBRACKET) ? LX_NORMAL : LX_BRACKET;
            LX_LINECMT:  nxt = (c == CH_NEWLINE) ? LX_NORMAL : LX_LINECMT;
            LX_BLOCKCMT: nxt = (c == CH_STAR) ? LX_STAR : LX_BLOCKCMT;
            default: begin
               case (c)
                  CH_DASH:      nxt = LX_DASH;
                  CH_HASH:      nxt = LX_LINECMT;
                  CH_SLASH:     nxt = LX_SLASH;
                  CH_SQUOTE:    nxt = LX_SQUOTE;
                  CH_DQUOTE:    nxt = LX_DQUOTE;
                  CH_BTICK:     nxt = LX_BTICK;
                  CH_LBRACKET:  nxt = LX_BRACKET;
                  CH_SEMICOLON: begin
                     nxt = LX_NORMAL;
                     sep = 1'b1;
                  end
                  default:      nxt = LX_NORMAL;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      blank     = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      seen_next = seen_ff | (!sep && !blank);
      stmt_end  = sep | item.end_of_script;

      result.out_byte       = sep ? 8'h00 : c;
      result.byte_valid     = !sep;
      result.statement_end  = stmt_end;
      result.statement_kept = stmt_end & seen_next;

      // Drop back to the normal context at the end of a script
      state_in = item.end_of_script ? LX_NORMAL : nxt;
      seen_in  = stmt_end ? 1'b0 : seen_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LX_NORMAL;
         seen_ff  <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

@@ src/sql_statement_splitter.sv @@
`timescale 1ns / 1ps

// SQL statement splitter: takes one script byte per request and returns one
// result per request, in order, at a sustained rate of one byte per clock
// while the output side does not stall. Each request is registered, runs
// through the lexer step (the 4-bit lexer state and the non-blank flag are
// the only loop) and lands in an output register. A separating semicolon
// comes out with byte_valid low and statement_end high; statement_kept tells
// whether the statement that ends held any non-whitespace byte. Setting
// end_of_script on the last byte also ends the statement and returns the
// lexer to its normal context. req_stall follows rsp_stall within the same
// cycle when both registers are full.
module sql_statement_splitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sss_pkg::rsp_type rsp_data
);
   import sss_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_result;
   logic    out_free;
   logic    advance;
   logic    req_take;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   sss_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ src/sss_checker.sv @@
`timescale 1ns / 1ps

module sss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sss_pkg::rsp_type rsp_data
);
   import sss_pkg::*;

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A dropped separator always ends a statement and carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |->
         rsp_data.statement_end && rsp_data.out_byte == 8'h00)
      else $error("separator result malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.statement_kept |-> rsp_data.statement_end)
      else $error("kept flag without statement end");

   // No result can appear in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present straight after reset");

   // A quiet cycle with no request and no result, followed by another, leaves nothing in flight
   assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid ##1 !req_valid && !rsp_valid |=> !rsp_valid)
      else $error("result without request");

endmodule

bind sql_statement_splitter sss_checker u_sss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import sss_pkg::*;

   localparam int RANDOM_BYTES = 800;
   localparam int STALL_LIMIT  = 2000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sql_statement_splitter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type       pending_requests [$];
   rsp_type       expected_results [$];
   lex_state_type scan_state    = LX_NORMAL;
   logic          nonblank_seen = 1'b0;
   int            total_requests   = 0;
   int            accepted_count   = 0;
   int            result_count     = 0;
   int            statements_ended = 0;
   int            statements_kept  = 0;
   int            mismatches       = 0;
   int            quiet_cycles     = 0;

   // Characters that move the lexer, weighted heavily in the random scripts
   logic [7:0] lexer_chars [12] = '{CH_DASH, CH_HASH, CH_SLASH, CH_STAR, CH_SQUOTE,
                                    CH_DQUOTE, CH_BTICK, CH_LBRACKET, CH_RBRACKET,
                                    CH_SEMICOLON, CH_BACKSLASH, CH_NEWLINE};
   logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   // Advance the splitter by one script byte and return its result
   function automatic rsp_type split_byte(input req_type r);
      rsp_type       o;
      lex_state_type s;
      lex_state_type ns;
      logic [7:0]    c;
      logic          sep;
      logic          done;
      logic          ends;
      c    = r.in_byte;
      s    = scan_state;
      ns   = LX_NORMAL;
      sep  = 1'b0;
      done = 1'b0;
      // complete a two-byte token first, else fall back to the plain context
      case (s)
         LX_DASH: begin
            if (c == CH_DASH) begin
               ns = LX_LINECMT;
               done = 1'b1;
            end else s = LX_NORMAL;
         end
         LX_SLASH: begin
            if (c == CH_STAR) begin
               ns = LX_STAR;
               done = 1'b1;
            end else s = LX_NORMAL;
         end
         LX_STAR: begin
            if (c == CH_SLASH) begin
               ns = LX_NORMAL;
               done = 1'b1;
            end else s = LX_BLOCKCMT;
         end
         LX_SESC: begin
            ns = LX_SQUOTE;
            done = 1'b1;
         end
         LX_DESC: begin
            ns = LX_DQUOTE;
            done = 1'b1;
         end
         default: ;
      endcase
      if (!done) begin
         case (s)
            LX_SQUOTE:   ns = (c == CH_BACKSLASH) ? LX_SESC :
                              (c == CH_SQUOTE) ? LX_NORMAL : LX_SQUOTE;
            LX_DQUOTE:   ns = (c == CH_BACKSLASH) ? LX_DESC :
                              (c == CH_DQUOTE) ? LX_NORMAL : LX_DQUOTE;
            LX_BTICK:    ns = (c == CH_BTICK) ? LX_NORMAL : LX_BTICK;
            LX_BRACKET:  ns = (c == CH_RBRACKET) ? LX_NORMAL : LX_BRACKET;
            LX_LINECMT:  ns = (c == CH_NEWLINE) ? LX_NORMAL : LX_LINECMT;
            LX_BLOCKCMT: ns = (c == CH_STAR) ? LX_STAR : LX_BLOCKCMT;
            default: begin
               case (c)
                  CH_DASH:      ns = LX_DASH;
                  CH_HASH:      ns = LX_LINECMT;
                  CH_SLASH:     ns = LX_SLASH;
                  CH_SQUOTE:    ns = LX_SQUOTE;
                  CH_DQUOTE:    ns = LX_DQUOTE;
                  CH_BTICK:     ns = LX_BTICK;
                  CH_LBRACKET:  ns = LX_BRACKET;
                  CH_SEMICOLON: sep = 1'b1;
                  default:      ns = LX_NORMAL;
               endcase
            end
         endcase
      end
      if (!sep && !(c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}))
         nonblank_seen = 1'b1;
      ends             = sep || r.end_of_script;
      o.out_byte       = sep ? 8'h00 : c;
      o.byte_valid     = !sep;
      o.statement_end  = ends;
      o.statement_kept = ends && nonblank_seen;
      if (ends) nonblank_seen = 1'b0;
      scan_state = r.end_of_script ? LX_NORMAL : ns;
      return o;
   endfunction

   task automatic queue_byte(input logic [7:0] c, input logic last);
      req_type r;
      r.in_byte       = c;
      r.end_of_script = last;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic queue_text(input string text, input logic ends_script);
      for (int i = 0; i < text.len(); i++)
         queue_byte(text[i], ends_script && (i == text.len() - 1));
   endtask

   function automatic logic [7:0] pick_script_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return lexer_chars[4'($urandom_range(0, 11))];
      if (roll < 60) return 8'h61 + 8'($urandom_range(0, 25));
      if (roll < 75) return blank_chars[3'($urandom_range(0, 5))];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int sender_idle_pct();
      if (accepted_count * 3 < total_requests) return 13;
      if (accepted_count * 3 < total_requests * 2) return 52;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (accepted_count * 3 < total_requests) return 52;
      if (accepted_count * 3 < total_requests * 2) return 13;
      return 0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at result %0d: %s", result_count, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Driver: hold a stalled request, otherwise offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.insert(expected_results.size(), split_byte(req_data));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 &&
                $urandom_range(0, 99) >= sender_idle_pct()) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin : monitor_proc
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("out_byte", int'(rsp_data.out_byte), int'(want.out_byte));
               check_field("byte_valid", int'(rsp_data.byte_valid),
                           int'(want.byte_valid));
               check_field("statement_end", int'(rsp_data.statement_end),
                           int'(want.statement_end));
               check_field("statement_kept", int'(rsp_data.statement_kept),
                           int'(want.statement_kept));
            end
            if (rsp_data.statement_end) statements_ended++;
            if (rsp_data.statement_kept) statements_kept++;
            result_count++;
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles", STALL_LIMIT);
         $display("tb failed");
         $finish;
      end
   end

   initial begin : stimulus_proc
      int len;
      int target;
      logic noise;
      // comment that opens and closes on the same star, then a final separator
      queue_text("/*/;*/;", 1'b1);
      // doubled quote reopens, escaped quote stays literal
      queue_text("'''\\'';", 1'b0);
      queue_text("\"\\\"\"[;]--;\n", 1'b0);
      // whitespace and a separator end the statement opened above, which is still kept
      queue_text(" \t;", 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      target = pending_requests.size() + RANDOM_BYTES;
      while (pending_requests.size() < target) begin
         len   = $urandom_range(1, 48);
         noise = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++)
            queue_byte(noise ? 8'($urandom_range(0, 255)) : pick_script_byte(),
                       i == len - 1);
      end
      total_requests = pending_requests.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d script bytes in random scripts and directed corner cases", total_requests);
      $display("%0d results, %0d statement ends, %0d kept",
               result_count, statements_ended, statements_kept);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/sss_pkg.sv
src/sss_lexer.sv
src/sql_statement_splitter.sv
src/sss_checker.sv
dv/tb.sv
